### design/ffha_pkg.sv
// Package for the first-fit heap allocator.
// Holds the default arena geometry, field widths, status codes and the controller states.
// Depends on nothing.
`default_nettype none

package ffha_pkg;

  localparam int unsigned ARENA_BYTES_DEF  = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam logic [31:0] ARENA_BASE_DEF   = 32'h0040_0000;

  localparam int unsigned REQ_W      = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - ADDR_W - STATUS_W;

  // Wide enough for offset + header + request and for size against request + header.
  localparam int unsigned CMP_W = 18;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_A_EVAL  = 6'b000100,
    S_A_SPLIT = 6'b001000,
    S_F_CHECK = 6'b010000,
    S_RESP    = 6'b100000
  } ctrl_state_t;

endpackage

`default_nettype wire

### design/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: controller around the header store.
// Depends on ffha_pkg and ffha_ram.
//
// After reset the block sweeps all ARENA_BYTES entries of the header store once,
// one entry per cycle, and takes no transaction until that pass is done. A free
// goes through a header check and the response state before its result is
// registered, or straight to the response state when the address is outside the
// arena. An allocation evaluates each header visited on the chain, then a split
// step when a block is split; the walk reads one header per cycle from the single
// read port of the header store, so its length grows with fragmentation. One item
// is in work at a time; a new one is accepted while the previous result waits,
// and a finished result holds the controller until the output register is free.
`default_nettype none

module first_fit_heap_allocator_unit #(
  parameter int unsigned ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter logic [31:0] ARENA_BASE   = ffha_pkg::ARENA_BASE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // request_size [15:0], release_address [47:16]
  input  wire logic [ffha_pkg::IN_DATA_W-1:0]  s_tdata,
  // action [0]
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // granted_address [31:0], status [33:32], zero fill [39:34]
  output logic      [ffha_pkg::OUT_DATA_W-1:0] m_tdata
);

  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(ARENA_BYTES);
  localparam int unsigned LW = $clog2(ARENA_BYTES + 1);
  localparam int unsigned SW = AW;
  localparam int unsigned DW = SW + LW + 2;

  ctrl_state_t       state, state_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic [AW-1:0]     off, off_next;
  logic [AW-1:0]     tail, tail_next;
  logic [REQ_W-1:0]  req, req_next;
  status_t           res_status, res_status_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  logic [SW-1:0] rd_size;
  logic [LW-1:0] rd_link;
  logic          rd_free, rd_present;

  logic [REQ_W-1:0]  in_size;
  logic [ADDR_W-1:0] in_addr, free_off;
  logic [CMP_W-1:0]  sz_c, req_c, off_c, next_c, tail_c, need_c;
  logic              out_free, take_exact, take_split, walk_end;
  logic [ADDR_W-1:0] payload;

  ffha_ram #(
    .DEPTH (ARENA_BYTES),
    .ADDR_W(AW),
    .DATA_W(DW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_size    = mem_rdata[SW-1:0];
  assign rd_link    = mem_rdata[SW +: LW];
  assign rd_free    = mem_rdata[SW+LW];
  assign rd_present = mem_rdata[SW+LW+1];

  assign in_size  = s_tdata[REQ_W-1:0];
  assign in_addr  = s_tdata[REQ_W +: ADDR_W];
  assign free_off = in_addr - ADDR_W'(HEADER_BYTES) - ARENA_BASE;

  assign sz_c   = CMP_W'(rd_size);
  assign req_c  = CMP_W'(req);
  assign off_c  = CMP_W'(off);
  assign next_c = CMP_W'(rd_link);
  assign need_c = req_c + CMP_W'(HEADER_BYTES);
  assign tail_c = off_c + need_c;

  assign take_exact = rd_free && (sz_c == req_c);
  assign take_split = rd_free && (sz_c > need_c) && (tail_c < CMP_W'(ARENA_BYTES));
  assign walk_end   = (next_c >= CMP_W'(ARENA_BYTES)) || (next_c <= off_c);
  assign payload    = ARENA_BASE + ADDR_W'(off) + ADDR_W'(HEADER_BYTES);

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    off_next        = off;
    tail_next       = tail;
    req_next        = req;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    mem_we          = 1'b0;
    mem_waddr       = off;
    mem_wdata       = '0;
    mem_raddr       = off;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == '0) begin
          mem_wdata = {1'b1, 1'b1, LW'(ARENA_BYTES), SW'(ARENA_BYTES - HEADER_BYTES)};
        end
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(ARENA_BYTES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          res_addr_next = '0;
          if (s_tuser == ACT_ALLOC) begin
            req_next   = in_size;
            off_next   = '0;
            mem_raddr  = '0;
            state_next = S_A_EVAL;
          end else if (free_off < ADDR_W'(ARENA_BYTES)) begin
            off_next   = free_off[AW-1:0];
            mem_raddr  = free_off[AW-1:0];
            state_next = S_F_CHECK;
          end else begin
            res_status_next = ST_BADFREE;
            state_next      = S_RESP;
          end
        end
      end
      S_A_EVAL: begin
        if (take_exact) begin
          mem_we          = 1'b1;
          mem_wdata       = {1'b1, 1'b0, rd_link, rd_size};
          res_status_next = ST_OK;
          res_addr_next   = payload;
          state_next      = S_RESP;
        end else if (take_split) begin
          mem_we     = 1'b1;
          mem_waddr  = tail_c[AW-1:0];
          mem_wdata  = {1'b1, 1'b1, rd_link, SW'(sz_c - need_c)};
          tail_next  = tail_c[AW-1:0];
          state_next = S_A_SPLIT;
        end else if (walk_end) begin
          res_status_next = ST_NOFIT;
          res_addr_next   = '0;
          state_next      = S_RESP;
        end else begin
          off_next  = rd_link[AW-1:0];
          mem_raddr = rd_link[AW-1:0];
        end
      end
      S_A_SPLIT: begin
        mem_we          = 1'b1;
        mem_wdata       = {1'b1, 1'b0, LW'(tail), SW'(req)};
        res_status_next = ST_OK;
        res_addr_next   = payload;
        state_next      = S_RESP;
      end
      S_F_CHECK: begin
        if (rd_present) begin
          mem_we          = 1'b1;
          mem_wdata       = {1'b1, 1'b1, rd_link, rd_size};
          res_status_next = ST_OK;
        end else begin
          res_status_next = ST_BADFREE;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (state == S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    off        <= off_next;
    tail       <= tail_next;
    req        <= req_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    if (state == S_RESP && out_free) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, res_status, res_addr};
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("controller accepted a transaction without leaving idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[ADDR_W +: STATUS_W] != ST_OK)) |-> (m_tdata[ADDR_W-1:0] == '0))
    else $error("failed transaction carries a nonzero address");

  a_split_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SPLIT) |-> ($past(state) == S_A_EVAL))
    else $error("split write not preceded by a chain evaluation");

  a_walk_forward: assert property (@(posedge clk) disable iff (rst)
    ((state == S_A_EVAL) && ($past(state) == S_A_EVAL)) |-> (off > $past(off)))
    else $error("chain walk did not advance to a higher offset");

endmodule

`default_nettype wire

### design/ffha_ram.sv
// Header store of the heap allocator: one write port, one registered read port.
// Used by first_fit_heap_allocator_unit; no package needed.
`default_nettype none

module ffha_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 27
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
